// ===== rtl/core/fcwt_pkg.sv =====
// Shared types and constants of the flow cache with timeouts.
// No dependencies; used by fcwt_ctrl, fcwt_dp and flow_cache_with_timeouts_unit.
package fcwt_pkg;

  localparam int unsigned ENTRIES_DEF = 32;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned MAX_RES     = 64;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [1:0] REG_ACTIVE   = 2'd0;
  localparam logic [1:0] REG_INACTIVE = 2'd1;
  localparam logic [1:0] REG_MAXFLOWS = 2'd2;

  localparam logic [15:0] ACTIVE_RST   = 16'd60;
  localparam logic [15:0] INACTIVE_RST = 16'd10;
  localparam logic [6:0]  MAXFLOWS_RST = 7'd32;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [19:0] US_MAX   = 20'd999999;
  // floor(us / 1000) == (us * MS_RECIP) >> MS_SHIFT for us below 2^20
  localparam logic [20:0] MS_RECIP = 21'd1073742;
  localparam int unsigned MS_SHIFT = 30;
  localparam logic [9:0]  MS_PER_S = 10'd1000;

  typedef struct packed {
    logic        req_type;
    logic        is_ipv4;
    logic [7:0]  ip_protocol;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  service_type;
    logic [15:0] packet_length;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] stamp_seconds;
    logic [19:0] stamp_micros;
  } in_t;

  typedef struct packed {
    logic [31:0] rec_source_ip;
    logic [31:0] rec_dest_ip;
    logic [15:0] rec_source_port;
    logic [15:0] rec_dest_port;
    logic [7:0]  rec_protocol;
    logic [7:0]  rec_service_type;
    logic [7:0]  rec_tcp_flags;
    logic [31:0] rec_packets;
    logic [31:0] rec_octets;
    logic [9:0]  rec_start_ms;
    logic [31:0] rec_finish_ms;
    logic        last_record;
  } out_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [7:0]  tos;
    logic [7:0]  flags;
    logic [31:0] pkts;
    logic [31:0] octs;
    logic [31:0] first_sec;
    logic [9:0]  first_ms;
    logic [31:0] last_sec;
    logic [31:0] finish_ms;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             rd;
    logic             exp;
    logic             upd;
    logic             ins;
    logic             fin;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic             flush;
    logic             ipv4;
    logic             proto_ok;
    logic             expire;
    logic             match;
    logic             full;
    logic             lim_hit;
    logic             can_exp;
    logic             pend;
    logic [POS_W-1:0] cnt;
  } stat_t;

endpackage

// ===== rtl/core/fcwt_ctrl.sv =====
// Sequencer of the flow cache: table walks for flush, expiry, match, eviction, limit.
// Depends on fcwt_pkg; drives the datapath fcwt_dp through cmd_t and reads stat_t.
module fcwt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           in_flush_i,
  input  fcwt_pkg::stat_t st_i,
  output fcwt_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEXT = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_INS  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [2:0] PH_FLUSH  = 3'd0;
  localparam logic [2:0] PH_EXPIRE = 3'd1;
  localparam logic [2:0] PH_MATCH  = 3'd2;
  localparam logic [2:0] PH_EVICT  = 3'd3;
  localparam logic [2:0] PH_LIMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic [fcwt_pkg::POS_W-1:0] pos_q, pos_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    pos_d      = pos_q;
    cmd_o      = '0;
    cmd_o.pos  = pos_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pos_d      = '0;
          phase_d    = in_flush_i ? PH_FLUSH : PH_EXPIRE;
          state_d    = S_NEXT;
        end
      end
      S_NEXT: begin
        case (phase_q)
          PH_FLUSH: state_d = (st_i.cnt != '0) ? S_RD : S_DONE;
          PH_EXPIRE: begin
            if (pos_q < st_i.cnt) begin
              state_d = S_RD;
            end else if (!st_i.ipv4) begin
              state_d = S_DONE;
            end else begin
              pos_d   = '0;
              phase_d = st_i.proto_ok ? PH_MATCH : PH_LIMIT;
            end
          end
          PH_MATCH: begin
            if (pos_q < st_i.cnt) begin
              state_d = S_RD;
            end else if (st_i.full) begin
              pos_d   = '0;
              phase_d = PH_EVICT;
              state_d = S_RD;
            end else begin
              state_d = S_INS;
            end
          end
          PH_LIMIT: state_d = st_i.lim_hit ? S_RD : S_DONE;
          default:  state_d = S_DONE;
        endcase
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        case (phase_q)
          PH_EXPIRE: begin
            if (!st_i.expire) begin
              pos_d   = pos_q + 1'b1;
              state_d = S_NEXT;
            end else if (st_i.can_exp) begin
              cmd_o.exp = 1'b1;
              state_d   = S_NEXT;
            end
          end
          PH_MATCH: begin
            if (st_i.match) begin
              state_d = S_UPD;
            end else begin
              pos_d   = pos_q + 1'b1;
              state_d = S_NEXT;
            end
          end
          default: begin
            if (st_i.can_exp) begin
              cmd_o.exp = 1'b1;
              state_d   = (phase_q == PH_EVICT) ? S_INS : S_NEXT;
            end
          end
        endcase
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        pos_d     = '0;
        phase_d   = PH_LIMIT;
        state_d   = S_NEXT;
      end
      S_INS: begin
        cmd_o.ins = 1'b1;
        pos_d     = '0;
        phase_d   = PH_LIMIT;
        state_d   = S_NEXT;
      end
      S_DONE: begin
        if (!st_i.pend) begin
          state_d = S_IDLE;
        end else if (st_i.can_exp) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_FLUSH;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== rtl/core/fcwt_dp.sv =====
// Datapath of the flow cache: flow memory, age list, valid bits, config and result stages.
// Depends on fcwt_pkg; commanded by fcwt_ctrl.
module fcwt_dp #(
  parameter int unsigned FLOW_ENTRIES = fcwt_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fcwt_pkg::in_t                  in_data_i,
  input  logic                           cfg_we_i,
  input  logic [fcwt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fcwt_pkg::CFG_W-1:0]     cfg_data_i,
  input  fcwt_pkg::cmd_t                 cmd_i,
  output fcwt_pkg::stat_t                st_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fcwt_pkg::out_t                 out_data_o
);

  localparam int unsigned IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int unsigned PW    = fcwt_pkg::POS_W;
  localparam logic [PW-1:0] ENT = PW'(FLOW_ENTRIES);

  logic [15:0] act_q, inact_q;
  logic [6:0]  maxf_q;

  fcwt_pkg::in_t  item_q, item_d;
  logic [9:0]     ms_q;
  fcwt_pkg::entry_t mem [FLOW_ENTRIES];
  fcwt_pkg::entry_t rd_q, wr_ent;
  logic [IDX_W-1:0] rd_slot_q, free_slot, wr_addr;
  logic [IDX_W-1:0] order_q [FLOW_ENTRIES];
  logic [FLOW_ENTRIES-1:0] valid_q;
  logic [PW-1:0]   cnt_q, lim;
  logic [31:0]     prod_q;
  logic [PW-1:0]   res_q;
  fcwt_pkg::out_t  pend_q, out_q, rec, pend_last;
  logic            pend_valid_q, out_valid_q, out_free;

  logic [19:0] us_sat;
  logic [40:0] ms_prod;
  logic        is_icmp, is_tcp;

  // Load: saturate micros, derive milliseconds, normalise the key
  always_comb begin
    us_sat  = (in_data_i.stamp_micros > fcwt_pkg::US_MAX) ? fcwt_pkg::US_MAX
                                                          : in_data_i.stamp_micros;
    ms_prod = {21'd0, us_sat} * {20'd0, fcwt_pkg::MS_RECIP};
    is_icmp = in_data_i.ip_protocol == fcwt_pkg::PROTO_ICMP;
    is_tcp  = in_data_i.ip_protocol == fcwt_pkg::PROTO_TCP;
    item_d  = in_data_i;
    if (is_icmp) begin
      item_d.src_port = '0;
      item_d.dst_port = '0;
    end
    if (!is_tcp) item_d.tcp_flag_bits = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_d;
      ms_q   <= ms_prod[fcwt_pkg::MS_SHIFT +: 10];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= fcwt_pkg::ACTIVE_RST;
      inact_q <= fcwt_pkg::INACTIVE_RST;
      maxf_q  <= fcwt_pkg::MAXFLOWS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcwt_pkg::REG_ACTIVE:   act_q   <= cfg_data_i;
        fcwt_pkg::REG_INACTIVE: inact_q <= cfg_data_i;
        fcwt_pkg::REG_MAXFLOWS: maxf_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_slot = IDX_W'(i);
    end
  end

  always_comb begin
    if (maxf_q == '0)             lim = PW'(1);
    else if (PW'(maxf_q) > ENT)   lim = ENT;
    else                          lim = PW'(maxf_q);
  end

  // Flow memory: one write, one registered read
  always_comb begin
    wr_ent  = rd_q;
    wr_addr = rd_slot_q;
    if (cmd_i.ins) begin
      wr_addr          = free_slot;
      wr_ent.src_ip    = item_q.source_ip;
      wr_ent.dst_ip    = item_q.dest_ip;
      wr_ent.sport     = item_q.src_port;
      wr_ent.dport     = item_q.dst_port;
      wr_ent.proto     = item_q.ip_protocol;
      wr_ent.tos       = item_q.service_type;
      wr_ent.flags     = item_q.tcp_flag_bits;
      wr_ent.pkts      = 32'd1;
      wr_ent.octs      = {16'd0, item_q.packet_length};
      wr_ent.first_sec = item_q.stamp_seconds;
      wr_ent.first_ms  = ms_q;
      wr_ent.last_sec  = item_q.stamp_seconds;
      wr_ent.finish_ms = {22'd0, ms_q};
    end else begin
      wr_ent.pkts      = rd_q.pkts + 32'd1;
      wr_ent.octs      = rd_q.octs + {16'd0, item_q.packet_length};
      wr_ent.finish_ms = prod_q + {22'd0, ms_q};
      wr_ent.last_sec  = item_q.stamp_seconds;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd || cmd_i.ins) mem[wr_addr] <= wr_ent;
    if (cmd_i.rd) begin
      rd_q      <= mem[order_q[cmd_i.pos[IDX_W-1:0]]];
      rd_slot_q <= order_q[cmd_i.pos[IDX_W-1:0]];
    end
    prod_q <= (item_q.stamp_seconds - rd_q.first_sec) * {22'd0, fcwt_pkg::MS_PER_S};
  end

  // Age list: close the gap on export, append on insert
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp) begin
      for (int k = 0; k < FLOW_ENTRIES - 1; k++) begin
        if (PW'(k) >= cmd_i.pos) order_q[k] <= order_q[k + 1];
      end
    end else if (cmd_i.ins) begin
      order_q[cnt_q[IDX_W-1:0]] <= free_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.exp) begin
      valid_q[rd_slot_q] <= 1'b0;
      cnt_q              <= cnt_q - 1'b1;
    end else if (cmd_i.ins) begin
      valid_q[free_slot] <= 1'b1;
      cnt_q              <= cnt_q + 1'b1;
    end
  end

  // Result stages: hold the newest record back until the next one or the end
  always_comb begin
    rec.rec_source_ip    = rd_q.src_ip;
    rec.rec_dest_ip      = rd_q.dst_ip;
    rec.rec_source_port  = rd_q.sport;
    rec.rec_dest_port    = rd_q.dport;
    rec.rec_protocol     = rd_q.proto;
    rec.rec_service_type = rd_q.tos;
    rec.rec_tcp_flags    = rd_q.flags;
    rec.rec_packets      = rd_q.pkts;
    rec.rec_octets       = rd_q.octs;
    rec.rec_start_ms     = rd_q.first_ms;
    rec.rec_finish_ms    = rd_q.finish_ms;
    rec.last_record      = 1'b0;
    pend_last            = pend_q;
    pend_last.last_record = 1'b1;
    out_free             = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp && res_q < PW'(fcwt_pkg::MAX_RES)) begin
      pend_q <= rec;
      if (pend_valid_q) out_q <= pend_q;
    end else if (cmd_i.fin) begin
      out_q <= pend_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      if (cmd_i.load) res_q <= '0;
      if (cmd_i.exp && res_q < PW'(fcwt_pkg::MAX_RES)) begin
        res_q        <= res_q + 1'b1;
        pend_valid_q <= 1'b1;
        if (pend_valid_q) begin
          out_valid_q <= 1'b1;
        end else if (out_valid_q && out_ready_i) begin
          out_valid_q <= 1'b0;
        end
      end else if (cmd_i.fin) begin
        pend_valid_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    st_o.flush    = item_q.req_type;
    st_o.ipv4     = item_q.is_ipv4;
    st_o.proto_ok = item_q.ip_protocol == fcwt_pkg::PROTO_TCP ||
                    item_q.ip_protocol == fcwt_pkg::PROTO_UDP ||
                    item_q.ip_protocol == fcwt_pkg::PROTO_ICMP;
    st_o.expire   = (item_q.stamp_seconds - rd_q.first_sec) >= {16'd0, act_q} ||
                    (item_q.stamp_seconds - rd_q.last_sec) >= {16'd0, inact_q};
    st_o.match    = rd_q.src_ip == item_q.source_ip && rd_q.dst_ip == item_q.dest_ip &&
                    rd_q.sport == item_q.src_port && rd_q.dport == item_q.dst_port &&
                    rd_q.proto == item_q.ip_protocol && rd_q.tos == item_q.service_type;
    st_o.full     = cnt_q >= ENT;
    st_o.lim_hit  = cnt_q != '0 && cnt_q >= lim;
    st_o.can_exp  = !pend_valid_q || out_free;
    st_o.pend     = pend_valid_q;
    st_o.cnt      = cnt_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/flow_cache_with_timeouts_unit.sv =====
// Top level of the flow cache with active and inactive timeouts.
// Depends on fcwt_pkg, fcwt_ctrl and fcwt_dp.
//
// The unit keeps up to FLOW_ENTRIES flows and works on one beat at a time.
// A packet beat first walks the age list to expire flows; for IPv4 TCP,
// UDP or ICMP it then walks it again to find a matching flow, and updates
// it or opens a new one, evicting the oldest if the table is full; for any
// IPv4 beat the oldest flows are then exported while the count is at or
// above the limit. Each visited entry passes a step, a memory read and an
// evaluation, and a flush beat exports every flow. Every exported flow,
// up to MAX_RES per input, leaves as one result beat; the last one caused
// by an input carries last_record. The newest record is held back so the
// flag can be set, and an export waits while a record is pending and the
// output register is full and not taken. Valid bits are cleared by reset,
// so no clearing pass is needed. Write configuration only while the unit
// is idle.
module flow_cache_with_timeouts_unit #(
  parameter int unsigned FLOW_ENTRIES = fcwt_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  fcwt_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fcwt_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [fcwt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fcwt_pkg::CFG_W-1:0]     cfg_data_i
);

  fcwt_pkg::cmd_t  cmd;
  fcwt_pkg::stat_t st;

  // Sequence the table walks
  fcwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_flush_i (in_data_i.req_type),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Hold the flows, the age order and the result stages
  fcwt_dp #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for flow_cache_with_timeouts_unit.
// Depends on fcwt_pkg and the RTL under rtl/; models the flow table itself
// and checks every exported record against its own prediction.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS      = fcwt_pkg::ENTRIES_DEF;
  localparam int unsigned STALL_MAX  = 20000; // cycles with no beat before giving up
  localparam int unsigned SETTLE     = 300;   // longest packet walk plus margin
  localparam int unsigned POOL_MAX   = 48;

  typedef struct {
    bit [7:0]  proto;
    bit [31:0] sip;
    bit [31:0] dip;
    bit [15:0] sp;
    bit [15:0] dp;
    bit [7:0]  tos;
  } flow_key_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  fcwt_pkg::in_t    in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  fcwt_pkg::out_t   out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [fcwt_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [fcwt_pkg::CFG_W-1:0] cfg_data_i  = '0;

  flow_cache_with_timeouts_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // Flow table mirror: one slot per flow, age_order lists slots oldest first
  // ---------------------------------------------------------------------
  bit [31:0] act_to   = 32'(fcwt_pkg::ACTIVE_RST);
  bit [31:0] inact_to = 32'(fcwt_pkg::INACTIVE_RST);
  bit [6:0]  flow_cap = fcwt_pkg::MAXFLOWS_RST;

  bit        slot_used [SLOTS];
  bit [31:0] slot_sip  [SLOTS];
  bit [31:0] slot_dip  [SLOTS];
  bit [15:0] slot_sp   [SLOTS];
  bit [15:0] slot_dp   [SLOTS];
  bit [7:0]  slot_pr   [SLOTS];
  bit [7:0]  slot_tos  [SLOTS];
  bit [7:0]  slot_flg  [SLOTS];
  bit [31:0] slot_pkts [SLOTS];
  bit [31:0] slot_octs [SLOTS];
  bit [31:0] slot_fsec [SLOTS];
  bit [9:0]  slot_fms  [SLOTS];
  bit [31:0] slot_lsec [SLOTS];
  bit [31:0] slot_fin  [SLOTS];
  int        age_order [$];

  fcwt_pkg::out_t beat_batch [$];   // records caused by the current input
  fcwt_pkg::out_t records_due [$];  // records still to arrive, oldest first
  fcwt_pkg::in_t  items_pending [$];
  int        mismatches = 0;

  // Export the flow at age position pos and close the gap in the age list.
  function automatic void retire_flow(int pos);
    int   s;
    fcwt_pkg::out_t rec;
    s = age_order[pos];
    rec.rec_source_ip    = slot_sip[s];
    rec.rec_dest_ip      = slot_dip[s];
    rec.rec_source_port  = slot_sp[s];
    rec.rec_dest_port    = slot_dp[s];
    rec.rec_protocol     = slot_pr[s];
    rec.rec_service_type = slot_tos[s];
    rec.rec_tcp_flags    = slot_flg[s];
    rec.rec_packets      = slot_pkts[s];
    rec.rec_octets       = slot_octs[s];
    rec.rec_start_ms     = slot_fms[s];
    rec.rec_finish_ms    = slot_fin[s];
    rec.last_record      = 1'b0;
    beat_batch.push_back(rec);
    slot_used[s] = 1'b0;
    age_order.delete(pos);
  endfunction

  // Work out the records one accepted beat causes and queue them.
  function automatic void predict_flow_exports(fcwt_pkg::in_t x);
    bit [31:0] t;
    bit [19:0] us;
    bit [9:0]  ms;
    bit [15:0] sp, dp;
    bit [7:0]  flg;
    bit [6:0]  lim;
    bit        hit;
    int        pos, s;
    beat_batch.delete();
    if (x.req_type) begin
      while (age_order.size() > 0) retire_flow(0);
    end else begin
      t  = x.stamp_seconds;
      us = (x.stamp_micros > fcwt_pkg::US_MAX) ? fcwt_pkg::US_MAX : x.stamp_micros;
      ms = 10'(us / 1000);
      pos = 0;
      while (pos < age_order.size()) begin
        s = age_order[pos];
        if ((t - slot_fsec[s]) >= act_to || (t - slot_lsec[s]) >= inact_to) retire_flow(pos);
        else pos++;
      end
      if (x.is_ipv4) begin
        if (x.ip_protocol == fcwt_pkg::PROTO_TCP || x.ip_protocol == fcwt_pkg::PROTO_UDP ||
            x.ip_protocol == fcwt_pkg::PROTO_ICMP) begin
          sp  = (x.ip_protocol == fcwt_pkg::PROTO_ICMP) ? 16'd0 : x.src_port;
          dp  = (x.ip_protocol == fcwt_pkg::PROTO_ICMP) ? 16'd0 : x.dst_port;
          flg = (x.ip_protocol == fcwt_pkg::PROTO_TCP) ? x.tcp_flag_bits : 8'd0;
          hit = 1'b0;
          foreach (age_order[p]) begin
            s = age_order[p];
            if (!hit && slot_sip[s] == x.source_ip && slot_dip[s] == x.dest_ip &&
                slot_sp[s] == sp && slot_dp[s] == dp && slot_pr[s] == x.ip_protocol &&
                slot_tos[s] == x.service_type) begin
              slot_pkts[s] = slot_pkts[s] + 1;
              slot_octs[s] = slot_octs[s] + x.packet_length;
              slot_fin[s]  = (t - slot_fsec[s]) * 32'd1000 + ms;
              slot_lsec[s] = t;
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (age_order.size() >= SLOTS) retire_flow(0);
            s = 0;
            while (s < SLOTS && slot_used[s]) s++;
            slot_used[s] = 1'b1;
            slot_sip[s]  = x.source_ip;
            slot_dip[s]  = x.dest_ip;
            slot_sp[s]   = sp;
            slot_dp[s]   = dp;
            slot_pr[s]   = x.ip_protocol;
            slot_tos[s]  = x.service_type;
            slot_flg[s]  = flg;
            slot_pkts[s] = 1;
            slot_octs[s] = 32'(x.packet_length);
            slot_fsec[s] = t;
            slot_fms[s]  = ms;
            slot_lsec[s] = t;
            slot_fin[s]  = 32'(ms);
            age_order.push_back(s);
          end
        end
        // limit check clamps the register to 1..table size
        lim = (flow_cap < 1) ? 7'd1 : (flow_cap > SLOTS) ? 7'(SLOTS) : flow_cap;
        while (age_order.size() > 0 && age_order.size() >= lim) retire_flow(0);
      end
    end
    if (beat_batch.size() > 0) beat_batch[beat_batch.size()-1].last_record = 1'b1;
    foreach (beat_batch[i]) records_due.push_back(beat_batch[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------
  flow_key_t key_pool [POOL_MAX];
  int        pool_n = 4;
  bit [31:0] now_s  = 32'd5000;
  bit        calm   = 1'b0;   // no idling on either side while set

  function automatic void refresh_key(int k);
    int r;
    r = $urandom_range(0, 99);
    key_pool[k].proto = (r < 40) ? fcwt_pkg::PROTO_TCP : (r < 70) ? fcwt_pkg::PROTO_UDP :
                        (r < 90) ? fcwt_pkg::PROTO_ICMP : 8'($urandom);
    key_pool[k].sip = $urandom;
    key_pool[k].dip = $urandom;
    key_pool[k].sp  = 16'($urandom);
    key_pool[k].dp  = 16'($urandom);
    key_pool[k].tos = 8'($urandom);
  endfunction

  function automatic fcwt_pkg::in_t mk(bit req, bit v4, bit [7:0] pr, bit [31:0] sip,
                                       bit [31:0] dip, bit [15:0] sp, bit [15:0] dp,
                                       bit [7:0] tos, bit [15:0] len, bit [7:0] flg,
                                       bit [31:0] sec, bit [19:0] us);
    fcwt_pkg::in_t x;
    x.req_type      = req;
    x.is_ipv4       = v4;
    x.ip_protocol   = pr;
    x.source_ip     = sip;
    x.dest_ip       = dip;
    x.src_port      = sp;
    x.dst_port      = dp;
    x.service_type  = tos;
    x.packet_length = len;
    x.tcp_flag_bits = flg;
    x.stamp_seconds = sec;
    x.stamp_micros  = us;
    return x;
  endfunction

  // Mostly packets of pooled flows with slowly advancing time; the rest
  // is flushes, non-IP frames, fresh keys and wild time jumps.
  function automatic fcwt_pkg::in_t random_item();
    fcwt_pkg::in_t x;
    int  r, k;
    r = $urandom_range(0, 99);
    if (r < 60) now_s = now_s + $urandom_range(0, 2);
    else if (r < 90) now_s = now_s + $urandom_range(3, 15);
    else if (r < 97) now_s = now_s + $urandom_range(16, 200);
    else now_s = $urandom;
    x = mk(1'b0, 1'b1, 8'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom),
           8'($urandom), 16'($urandom), 8'($urandom), now_s,
           ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999)));
    r = $urandom_range(0, 99);
    if (r < 3) begin
      x.req_type = 1'b1;
      x.is_ipv4  = 1'($urandom);
    end else if (r >= 10) begin
      k = $urandom_range(0, pool_n - 1);
      if ($urandom_range(0, 19) == 0) refresh_key(k);
      x.ip_protocol  = key_pool[k].proto;
      x.source_ip    = key_pool[k].sip;
      x.dest_ip      = key_pool[k].dip;
      x.src_port     = key_pool[k].sp;
      x.dst_port     = key_pool[k].dp;
      x.service_type = key_pool[k].tos;
    end else begin
      x.is_ipv4 = 1'b0;
    end
    return x;
  endfunction

  // Most gaps short, a few long.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 80);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offer pending items, hold each beat until taken
  // ---------------------------------------------------------------------
  int unsigned tx_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_flow_exports(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap != 0) begin
          tx_gap     <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (items_pending.size() > 0) begin
          in_data_i  <= items_pending.pop_front();
          in_valid_i <= 1'b1;
          tx_gap     <= (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off on request
  // ---------------------------------------------------------------------
  int unsigned rx_gap    = 0;
  int unsigned hold_left = 0;
  logic        hold_go   = 1'b0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap      <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) rx_gap <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each record beat with the oldest prediction
  // ---------------------------------------------------------------------
  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    fcwt_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (records_due.size() == 0) begin
        note_mismatch("record with none due", '0, '0);
      end else begin
        want = records_due.pop_front();
        if (out_data_o.rec_source_ip !== want.rec_source_ip)
          note_mismatch("rec_source_ip", out_data_o.rec_source_ip, want.rec_source_ip);
        if (out_data_o.rec_dest_ip !== want.rec_dest_ip)
          note_mismatch("rec_dest_ip", out_data_o.rec_dest_ip, want.rec_dest_ip);
        if (out_data_o.rec_source_port !== want.rec_source_port)
          note_mismatch("rec_source_port", out_data_o.rec_source_port, want.rec_source_port);
        if (out_data_o.rec_dest_port !== want.rec_dest_port)
          note_mismatch("rec_dest_port", out_data_o.rec_dest_port, want.rec_dest_port);
        if (out_data_o.rec_protocol !== want.rec_protocol)
          note_mismatch("rec_protocol", out_data_o.rec_protocol, want.rec_protocol);
        if (out_data_o.rec_service_type !== want.rec_service_type)
          note_mismatch("rec_service_type", out_data_o.rec_service_type,
                        want.rec_service_type);
        if (out_data_o.rec_tcp_flags !== want.rec_tcp_flags)
          note_mismatch("rec_tcp_flags", out_data_o.rec_tcp_flags, want.rec_tcp_flags);
        if (out_data_o.rec_packets !== want.rec_packets)
          note_mismatch("rec_packets", out_data_o.rec_packets, want.rec_packets);
        if (out_data_o.rec_octets !== want.rec_octets)
          note_mismatch("rec_octets", out_data_o.rec_octets, want.rec_octets);
        if (out_data_o.rec_start_ms !== want.rec_start_ms)
          note_mismatch("rec_start_ms", out_data_o.rec_start_ms, want.rec_start_ms);
        if (out_data_o.rec_finish_ms !== want.rec_finish_ms)
          note_mismatch("rec_finish_ms", out_data_o.rec_finish_ms, want.rec_finish_ms);
        if (out_data_o.last_record !== want.last_record)
          note_mismatch("last_record", out_data_o.last_record, want.last_record);
      end
    end
  end

  // Watchdog: any beat or register write restarts the count.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------
  task automatic write_reg(logic [fcwt_pkg::CFG_IDX_W-1:0] idx,
                           logic [fcwt_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      fcwt_pkg::REG_ACTIVE:   act_to   = 32'(val);
      fcwt_pkg::REG_INACTIVE: inact_to = 32'(val);
      fcwt_pkg::REG_MAXFLOWS: flow_cap = val[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] a, logic [15:0] i, logic [6:0] m);
    write_reg(fcwt_pkg::REG_ACTIVE, a);
    write_reg(fcwt_pkg::REG_INACTIVE, i);
    write_reg(fcwt_pkg::REG_MAXFLOWS, {9'd0, m});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every item is taken and every record has come, then let
  // the last walk finish so the block is idle.
  task automatic drain();
    while (items_pending.size() != 0 || in_valid_i || records_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_random(int n, int keys);
    pool_n = keys;
    repeat (n) items_pending.push_back(random_item());
  endtask

  initial begin
    foreach (key_pool[k]) refresh_key(k);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats under reset defaults
    calm = 1'b1;
    items_pending.push_back(mk(1, 1, fcwt_pkg::PROTO_TCP, 0, 0, 0, 0, 0, 0, 0, 1000, 0));
    items_pending.push_back(mk(0, 1, fcwt_pkg::PROTO_TCP, '1, '1, '1, '1, '1, '1, '1, 1000,
                               fcwt_pkg::US_MAX));
    items_pending.push_back(mk(0, 1, fcwt_pkg::PROTO_TCP, '1, '1, '1, '1, '1, 100, 8'h12,
                               1001, 0));
    // UDP flags dropped, ICMP ports dropped, micros saturated
    items_pending.push_back(mk(0, 1, fcwt_pkg::PROTO_UDP, 0, 0, 0, 0, 0, 0, '1, 1001, 1000));
    items_pending.push_back(mk(0, 1, fcwt_pkg::PROTO_ICMP, 32'h0a000001, 32'h0a000002, 1234,
                               5678, 8'h10, 64, 8'h02, 1002, 20'hFFFFF));
    items_pending.push_back(mk(0, 1, fcwt_pkg::PROTO_ICMP, 32'h0a000001, 32'h0a000002, 999,
                               111, 8'h10, 64, 8'h02, 1003, 20'd500123));
    // other protocols and a non-IP frame open nothing
    items_pending.push_back(mk(0, 1, 8'd255, 1, 2, 3, 4, 5, 6, 7, 1003, 0));
    items_pending.push_back(mk(0, 1, 8'd0, 1, 2, 3, 4, 5, 6, 7, 1003, 0));
    items_pending.push_back(mk(0, 0, fcwt_pkg::PROTO_TCP, 9, 9, 9, 9, 9, 9, 9, 1004, 0));
    items_pending.push_back(mk(0, 1, fcwt_pkg::PROTO_TCP, 32'h55aa55aa, 32'haa55aa55, 80,
                               443, 0, 1500, 8'h18, 1004, 0));
    // idle for the inactive timeout: everything goes
    items_pending.push_back(mk(0, 0, 8'd0, 0, 0, 0, 0, 0, 0, 0, 1014, 0));
    // keep one flow busy until the active timeout retires it
    for (int s = 1020; s <= 1074; s += 9)
      items_pending.push_back(mk(0, 1, fcwt_pkg::PROTO_TCP, 7, 8, 9, 10, 11, 40, 8'h10, s,
                                 20'd1999));
    items_pending.push_back(mk(0, 0, 8'd0, 0, 0, 0, 0, 0, 0, 0, 1080, 0));
    // time running backwards ages a flow to near 2^32
    items_pending.push_back(mk(0, 1, fcwt_pkg::PROTO_TCP, 1, 1, 1, 1, 1, 1, 1, 1081, 0));
    items_pending.push_back(mk(0, 1, fcwt_pkg::PROTO_UDP, 2, 2, 2, 2, 2, 2, 2, 5, 0));
    items_pending.push_back(mk(1, 0, 8'd0, 0, 0, 0, 0, 0, 0, 0, 5, 0));
    drain();
    calm = 1'b0;

    // zero timeouts: every flow expires at the next packet
    configure(16'd0, 16'd0, 7'd32);
    run_random(10, 4);
    drain();

    // largest timeouts, limit above table size, many keys: open many flows
    // while the receiver holds off
    configure(16'hFFFF, 16'hFFFF, 7'd64);
    run_random(28, POOL_MAX);
    hold_go <= 1'b1;
    drain();

    configure(16'd30, 16'd5, 7'd1);
    run_random(12, 4);
    drain();

    configure(16'd45, 16'd8, 7'd0);
    run_random(10, 6);
    drain();

    // open flows with a wide limit, then lower it under live flows
    calm = 1'b1;
    configure(16'd2000, 16'd1000, 7'd127);
    run_random(20, 24);
    drain();
    calm = 1'b0;
    configure(16'd2000, 16'd1000, 7'd2);
    run_random(12, 8);
    drain();

    configure(16'hFFFF, 16'd3, 7'd10);
    run_random(10, 12);
    items_pending.push_back(mk(1, 1, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== flow_cache_with_timeouts_unit.f =====
rtl/core/fcwt_pkg.sv
rtl/core/fcwt_ctrl.sv
rtl/core/fcwt_dp.sv
rtl/core/flow_cache_with_timeouts_unit.sv
bench/tb_top.sv
